// ----- hw/rtl/split_direct_mapped_cache_tags_macros.svh -----
// ============================================================================
// Assertion macros for the split direct-mapped cache tag block
// Implication checks on the rising clock edge; they expand to nothing when
// SYNTH is defined.
// ============================================================================
`ifndef SPLIT_DIRECT_MAPPED_CACHE_TAGS_MACROS_SVH
`define SPLIT_DIRECT_MAPPED_CACHE_TAGS_MACROS_SVH

`ifndef SYNTH

// Antecedent implies consequent in the same cycle.
`define SDMCT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdmct assertion failed");

// Antecedent implies consequent in the following cycle.
`define SDMCT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdmct assertion failed");

`else

`define SDMCT_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SDMCT_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/sdmct_pkg.sv -----
// ============================================================================
// sdmct_pkg
// Types and constants shared by the split direct-mapped cache tag block.
// ============================================================================
package sdmct_pkg;

    // Field and datapath widths
    localparam int ADDR_W      = 32;
    localparam int WADDR_W     = 30;
    localparam int TAG_W       = 30;
    localparam int WORDS_W     = 9;
    localparam int LINES_W     = 11;
    localparam int SPAN_W      = WORDS_W + LINES_W;
    localparam int WOFF_W      = 8;
    localparam int INDEX_OUT_W = 10;
    localparam int BYTE_W      = 2;
    localparam int COUNT_W     = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    // One quotient bit per division step, over the whole word address
    localparam int DIV_STEPS = WADDR_W;
    localparam int STEP_W    = 5;

    // Register reset values and limits
    localparam logic [WORDS_W-1:0] LINE_WORDS_MAX   = 9'd256;
    localparam logic [WORDS_W-1:0] RESET_LINE_WORDS = 9'd4;
    localparam logic [LINES_W-1:0] RESET_NUM_LINES  = 11'd1024;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;

    // Configuration register indexes
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_INS_LINE_WORDS  = 2'd0;
    localparam cfg_index_t CFG_INS_NUM_LINES   = 2'd1;
    localparam cfg_index_t CFG_DATA_LINE_WORDS = 2'd2;
    localparam cfg_index_t CFG_DATA_NUM_LINES  = 2'd3;

    // One access beat
    typedef struct packed {
        logic [ADDR_W-1:0] byte_address;
        logic              ins_select;
    } access_t;

    // One result beat
    typedef struct packed {
        logic                   hit;
        logic [INDEX_OUT_W-1:0] line_index;
        logic [TAG_W-1:0]       line_tag;
        logic [WOFF_W-1:0]      word_in_line;
        logic [BYTE_W-1:0]      byte_in_word;
        logic [COUNT_W-1:0]     access_total;
        logic [COUNT_W-1:0]     hit_total;
    } result_t;

    // One tag memory word
    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
    } tag_entry_t;

    localparam int ENTRY_W = TAG_W + 1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_MUL,
        S_IDX,
        S_CHECK
    } state_t;

endpackage

// ----- hw/rtl/sdmct_ram.sv -----
// ============================================================================
// sdmct_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ============================================================================
module sdmct_ram
#(
    parameter int WIDTH = 31,
    parameter int DEPTH = 2048
)
(
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/split_direct_mapped_cache_tags.sv -----
// ============================================================================
// split_direct_mapped_cache_tags
// Hit/miss tracking for split instruction and data direct-mapped caches.
// ============================================================================
// An access runs from its accept through the SETUP, DIV, MUL, IDX and CHECK
// states: SETUP forms the line span (line words times line count), DIV runs
// the restoring division that yields one quotient bit per cycle for both the
// word address over the line size and the word address over the span, MUL
// forms the multiply that recovers the line index, IDX forms the index and
// reads the tag memory, and CHECK compares, writes back on a miss and loads
// the result register, waiting while a stalled result still holds it. One
// access is in flight at a time; a new one is taken while the previous
// result still waits in the output register. Both caches share one tag
// memory of 2**(clog2(MAX_LINES)+1) words; after reset a clearing pass over
// every word runs before the first access is taken, while configuration
// writes are accepted throughout. Line sizes and counts need not be powers
// of two; out-of-range settings are clamped.
// ============================================================================
`include "split_direct_mapped_cache_tags_macros.svh"

module split_direct_mapped_cache_tags
    import sdmct_pkg::*;
#(
    parameter int MAX_LINES = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  access_t               req_data,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output result_t               rsp_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int RAM_AW    = $clog2(MAX_LINES) + 1;
    localparam int RAM_DEPTH = 2 ** RAM_AW;
    localparam logic [LINES_W-1:0] LINES_CAP = LINES_W'(MAX_LINES);

    // Clamp a line size into 1 .. 256
    function automatic logic [WORDS_W-1:0] clamp_words(input logic [WORDS_W-1:0] v);
        logic [WORDS_W-1:0] r;
        begin
            r = v;
            if (v == '0)
            begin
                r = WORDS_W'(1);
            end
            else if (v > LINE_WORDS_MAX)
            begin
                r = LINE_WORDS_MAX;
            end
            return r;
        end
    endfunction

    // Clamp a line count into 1 .. MAX_LINES
    function automatic logic [LINES_W-1:0] clamp_lines(input logic [LINES_W-1:0] v);
        logic [LINES_W-1:0] r;
        begin
            r = v;
            if (v == '0)
            begin
                r = LINES_W'(1);
            end
            else if (int'(v) > MAX_LINES)
            begin
                r = LINES_CAP;
            end
            return r;
        end
    endfunction

    // Tag memory address: cache select on top, line index below
    function automatic logic [RAM_AW-1:0] line_addr(input logic sel,
                                                    input logic [LINES_W-1:0] idx);
        begin
            return (RAM_AW'(sel) << (RAM_AW - 1)) | RAM_AW'(idx);
        end
    endfunction

    // Control state
    state_t              state_reg;
    state_t              state_next;
    logic [RAM_AW-1:0]   clear_cnt_reg;
    logic [STEP_W-1:0]   step_cnt_reg;
    logic                rsp_valid_reg;

    // Configuration registers
    logic [WORDS_W-1:0]  ins_words_cfg_reg;
    logic [LINES_W-1:0]  ins_lines_cfg_reg;
    logic [WORDS_W-1:0]  data_words_cfg_reg;
    logic [LINES_W-1:0]  data_lines_cfg_reg;

    // Counters
    logic [COUNT_W-1:0]  ins_acc_cnt_reg;
    logic [COUNT_W-1:0]  ins_hit_cnt_reg;
    logic [COUNT_W-1:0]  data_acc_cnt_reg;
    logic [COUNT_W-1:0]  data_hit_cnt_reg;

    // Per-access datapath
    logic                sel_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic [WORDS_W-1:0]  words_reg;
    logic [LINES_W-1:0]  lines_reg;
    logic [SPAN_W-1:0]   span_reg;
    logic [WADDR_W-1:0]  q_a_reg;
    logic [WORDS_W-1:0]  rem_a_reg;
    logic [WADDR_W-1:0]  q_b_reg;
    logic [SPAN_W-1:0]   rem_b_reg;
    logic [TAG_W-1:0]    prod_reg;
    logic [LINES_W-1:0]  idx_reg;
    result_t             rsp_data_reg;

    // Control strobes
    logic                req_fire;
    logic                check_fire;
    logic                div_last;

    // Division step logic
    logic [WORDS_W:0]    trial_a;
    logic                ge_a;
    logic [SPAN_W:0]     trial_b;
    logic                ge_b;

    // Index, tag memory and update logic
    logic [TAG_W+LINES_W-1:0] mul_full;
    logic [WADDR_W-1:0]  idx_diff;
    logic [LINES_W-1:0]  idx_calc;
    tag_entry_t          entry;
    tag_entry_t          new_entry;
    logic                hit;
    logic                ram_we;
    logic                ram_re;
    logic [RAM_AW-1:0]   ram_waddr;
    logic [RAM_AW-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [COUNT_W-1:0]  acc_sel;
    logic [COUNT_W-1:0]  hit_sel;
    logic [COUNT_W-1:0]  acc_new;
    logic [COUNT_W-1:0]  hit_new;

    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign div_last  = (step_cnt_reg == STEP_W'(DIV_STEPS - 1));

    // Sequencer: next state and strobes
    always_comb
    begin
        state_next = state_reg;
        check_fire = 1'b0;
        ram_re     = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (&clear_cnt_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_last)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_IDX;
            end
            S_IDX:
            begin
                ram_re     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    check_fire = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer state, clearing sweep and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clear_cnt_reg <= '0;
            step_cnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clear_cnt_reg <= clear_cnt_reg + RAM_AW'(1);
            end
            if (state_reg == S_DIV)
            begin
                step_cnt_reg <= step_cnt_reg + STEP_W'(1);
            end
            else
            begin
                step_cnt_reg <= '0;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ins_words_cfg_reg  <= RESET_LINE_WORDS;
            ins_lines_cfg_reg  <= RESET_NUM_LINES;
            data_words_cfg_reg <= RESET_LINE_WORDS;
            data_lines_cfg_reg <= RESET_NUM_LINES;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_INS_LINE_WORDS:  ins_words_cfg_reg  <= cfg_data[WORDS_W-1:0];
                CFG_INS_NUM_LINES:   ins_lines_cfg_reg  <= cfg_data[LINES_W-1:0];
                CFG_DATA_LINE_WORDS: data_words_cfg_reg <= cfg_data[WORDS_W-1:0];
                CFG_DATA_NUM_LINES:  data_lines_cfg_reg <= cfg_data[LINES_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Restoring division steps for both quotients
    assign trial_a = {rem_a_reg, q_a_reg[WADDR_W-1]};
    assign ge_a    = (trial_a >= {1'b0, words_reg});
    assign trial_b = {rem_b_reg, q_b_reg[WADDR_W-1]};
    assign ge_b    = (trial_b >= {1'b0, span_reg});

    // Line index is the first quotient less the tag times the line count
    assign mul_full = (TAG_W + LINES_W)'(q_b_reg) * (TAG_W + LINES_W)'(lines_reg);
    assign idx_diff = q_a_reg - prod_reg;
    assign idx_calc = idx_diff[LINES_W-1:0];

    // Per-access datapath registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            sel_reg   <= req_data.ins_select;
            byte_reg  <= req_data.byte_address[BYTE_W-1:0];
            q_a_reg   <= req_data.byte_address[ADDR_W-1:BYTE_W];
            q_b_reg   <= req_data.byte_address[ADDR_W-1:BYTE_W];
            rem_a_reg <= '0;
            rem_b_reg <= '0;
            words_reg <= clamp_words(req_data.ins_select ? ins_words_cfg_reg
                                                         : data_words_cfg_reg);
            lines_reg <= clamp_lines(req_data.ins_select ? ins_lines_cfg_reg
                                                         : data_lines_cfg_reg);
        end
        if (state_reg == S_SETUP)
        begin
            span_reg <= SPAN_W'(words_reg) * SPAN_W'(lines_reg);
        end
        if (state_reg == S_DIV)
        begin
            rem_a_reg <= ge_a ? WORDS_W'(trial_a - {1'b0, words_reg}) : trial_a[WORDS_W-1:0];
            q_a_reg   <= {q_a_reg[WADDR_W-2:0], ge_a};
            rem_b_reg <= ge_b ? SPAN_W'(trial_b - {1'b0, span_reg}) : trial_b[SPAN_W-1:0];
            q_b_reg   <= {q_b_reg[WADDR_W-2:0], ge_b};
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= mul_full[TAG_W-1:0];
        end
        if (state_reg == S_IDX)
        begin
            idx_reg <= idx_calc;
        end
    end

    // Tag memory access: clearing sweep, lookup read, write-back on a miss
    assign entry           = tag_entry_t'(ram_rdata);
    assign hit             = entry.valid && (entry.tag == q_b_reg);
    assign new_entry.valid = 1'b1;
    assign new_entry.tag   = q_b_reg;
    assign ram_we          = (state_reg == S_CLEAR) || (check_fire && !hit);
    assign ram_waddr       = (state_reg == S_CLEAR) ? clear_cnt_reg : line_addr(sel_reg, idx_reg);
    assign ram_raddr       = line_addr(sel_reg, idx_calc);

    sdmct_ram
    #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    )
    u_tag_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ((state_reg == S_CLEAR) ? ENTRY_W'(0) : ENTRY_W'(new_entry)),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Saturating counts of the selected cache
    assign acc_sel = sel_reg ? ins_acc_cnt_reg : data_acc_cnt_reg;
    assign hit_sel = sel_reg ? ins_hit_cnt_reg : data_hit_cnt_reg;
    assign acc_new = (acc_sel == COUNT_MAX) ? acc_sel : acc_sel + COUNT_W'(1);
    assign hit_new = (hit && (hit_sel != COUNT_MAX)) ? hit_sel + COUNT_W'(1) : hit_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ins_acc_cnt_reg  <= '0;
            ins_hit_cnt_reg  <= '0;
            data_acc_cnt_reg <= '0;
            data_hit_cnt_reg <= '0;
        end
        else if (check_fire)
        begin
            if (sel_reg)
            begin
                ins_acc_cnt_reg <= acc_new;
                ins_hit_cnt_reg <= hit_new;
            end
            else
            begin
                data_acc_cnt_reg <= acc_new;
                data_hit_cnt_reg <= hit_new;
            end
        end
    end

    // Result register: a finished beat waits here while the next access starts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (check_fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (check_fire)
        begin
            rsp_data_reg.hit          <= hit;
            rsp_data_reg.line_index   <= INDEX_OUT_W'(idx_reg);
            rsp_data_reg.line_tag     <= q_b_reg;
            rsp_data_reg.word_in_line <= rem_a_reg[WOFF_W-1:0];
            rsp_data_reg.byte_in_word <= byte_reg;
            rsp_data_reg.access_total <= acc_new;
            rsp_data_reg.hit_total    <= hit_new;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // Assertions
    `SDMCT_ASSERT_NXT(a_accept_starts_setup, clk, rst_n, req_fire, state_reg == S_SETUP)
    `SDMCT_ASSERT_IMP(a_rem_below_words, clk, rst_n, state_reg == S_MUL, rem_a_reg < words_reg)
    `SDMCT_ASSERT_IMP(a_rem_below_span, clk, rst_n, state_reg == S_MUL, rem_b_reg < span_reg)
    `SDMCT_ASSERT_IMP(a_index_in_range, clk, rst_n, state_reg == S_CHECK, idx_reg < lines_reg)
    `SDMCT_ASSERT_IMP(a_ins_hits_bounded, clk, rst_n, 1'b1, ins_hit_cnt_reg <= ins_acc_cnt_reg)
    `SDMCT_ASSERT_IMP(a_data_hits_bounded, clk, rst_n, 1'b1, data_hit_cnt_reg <= data_acc_cnt_reg)

endmodule

// ----- tb/sv/sdmct_lookup_checker.sv -----
// ============================================================================
// sdmct_lookup_checker
// Watches the access, result and register channels of the split cache tag
// block. It keeps its own copy of both tag stores, the valid bits, the
// saturating counters and the line geometry, predicts the result of every
// accepted access and compares each result beat, field by field, with the
// oldest prediction still waiting.
// ============================================================================
module sdmct_lookup_checker
    import sdmct_pkg::*;
#(
    parameter int MAX_LINES = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_stall,
    input  access_t               req_data,
    input  logic                  rsp_valid,
    input  logic                  rsp_stall,
    input  result_t               rsp_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    awaited_beats
);

    localparam int DATA_BANK = 0;
    localparam int INS_BANK  = 1;

    // Model of both caches: bank 1 is the instruction cache, bank 0 the data cache.
    logic [TAG_W-1:0]   tag_copy [2][MAX_LINES];
    bit                 line_valid [2][MAX_LINES];
    logic [COUNT_W-1:0] access_seen [2];
    logic [COUNT_W-1:0] hit_seen [2];
    logic [WORDS_W-1:0] words_setting [2];
    logic [LINES_W-1:0] lines_setting [2];

    result_t            predicted_results [$];
    result_t            oldest;

    // Splits the word address by the clamped geometry, looks the line up and
    // updates the tag copy and the counters as the block does.
    function automatic result_t predict_lookup(input access_t acc);
        int unsigned bank;
        int unsigned words;
        int unsigned lines;
        int unsigned waddr;
        int unsigned idx;
        int unsigned tag;
        result_t     r;
        bank  = acc.ins_select ? INS_BANK : DATA_BANK;
        words = 32'(words_setting[bank]);
        lines = 32'(lines_setting[bank]);
        if (words == 0)
            words = 1;
        else if (words > LINE_WORDS_MAX)
            words = 32'(LINE_WORDS_MAX);
        if (lines == 0)
            lines = 1;
        else if (lines > MAX_LINES)
            lines = MAX_LINES;
        waddr = 32'(acc.byte_address[ADDR_W-1:BYTE_W]);
        idx   = (waddr / words) % lines;
        tag   = waddr / (words * lines);

        if (access_seen[bank] != COUNT_MAX)
            access_seen[bank] = access_seen[bank] + COUNT_W'(1);
        r.hit = line_valid[bank][idx] && (tag_copy[bank][idx] == TAG_W'(tag));
        if (r.hit)
        begin
            if (hit_seen[bank] != COUNT_MAX)
                hit_seen[bank] = hit_seen[bank] + COUNT_W'(1);
        end
        else
        begin
            tag_copy[bank][idx]   = TAG_W'(tag);
            line_valid[bank][idx] = 1'b1;
        end

        r.line_index   = INDEX_OUT_W'(idx);
        r.line_tag     = TAG_W'(tag);
        r.word_in_line = WOFF_W'(waddr % words);
        r.byte_in_word = acc.byte_address[BYTE_W-1:0];
        r.access_total = access_seen[bank];
        r.hit_total    = hit_seen[bank];
        return r;
    endfunction

    task automatic compare_field(input string label, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    // Predictions on access beats, register writes and checks on result beats.
    // An access accepted together with a register write still uses the old
    // geometry, as the block does.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < 2; b++)
            begin
                for (int i = 0; i < MAX_LINES; i++)
                    line_valid[b][i] = 1'b0;
                access_seen[b]   = '0;
                hit_seen[b]      = '0;
                words_setting[b] = RESET_LINE_WORDS;
                lines_setting[b] = RESET_NUM_LINES;
            end
            predicted_results.delete();
            mismatch_count = 0;
            awaited_beats <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                predicted_results.push_back(predict_lookup(req_data));

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_INS_LINE_WORDS:  words_setting[INS_BANK]  = cfg_data[WORDS_W-1:0];
                    CFG_INS_NUM_LINES:   lines_setting[INS_BANK]  = cfg_data[LINES_W-1:0];
                    CFG_DATA_LINE_WORDS: words_setting[DATA_BANK] = cfg_data[WORDS_W-1:0];
                    CFG_DATA_NUM_LINES:  lines_setting[DATA_BANK] = cfg_data[LINES_W-1:0];
                    default: ;
                endcase
            end

            if (rsp_valid && !rsp_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, expected none, actual %h",
                             $time, rsp_data);
                    mismatch_count++;
                end
                else
                begin
                    oldest = predicted_results.pop_front();
                    compare_field("hit", 64'(oldest.hit), 64'(rsp_data.hit));
                    compare_field("line_index", 64'(oldest.line_index),
                                  64'(rsp_data.line_index));
                    compare_field("line_tag", 64'(oldest.line_tag),
                                  64'(rsp_data.line_tag));
                    compare_field("word_in_line", 64'(oldest.word_in_line),
                                  64'(rsp_data.word_in_line));
                    compare_field("byte_in_word", 64'(oldest.byte_in_word),
                                  64'(rsp_data.byte_in_word));
                    compare_field("access_total", 64'(oldest.access_total),
                                  64'(rsp_data.access_total));
                    compare_field("hit_total", 64'(oldest.hit_total),
                                  64'(rsp_data.hit_total));
                end
            end

            awaited_beats <= predicted_results.size();
        end
    end

endmodule

// ----- tb/sv/tb_split_direct_mapped_cache_tags.sv -----
// ============================================================================
// tb_split_direct_mapped_cache_tags
// Drives accesses and register writes into the split cache tag block. A short
// directed run covers address extremes, hits, evictions and clamped line
// geometry; phases of random accesses with address locality follow under
// several line geometries, with random access gaps and result stalls.
// ============================================================================
module tb_split_direct_mapped_cache_tags;
    import sdmct_pkg::*;

    localparam int MAX_LINES    = 1024;
    localparam int CLK_PERIOD   = 12;
    localparam int PHASE_ITEMS  = 200;
    localparam int SETTLE_TICKS = 40;
    localparam int LIMIT_CYCLES = 600000;
    localparam int NUM_PHASES   = 10;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    access_t               req_data  = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    result_t               rsp_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index = CFG_INS_LINE_WORDS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int                    mismatch_count;
    int                    awaited_beats;
    logic                  calm = 1'b0;
    int                    stall_left = 0;
    int                    stall_draw;
    logic [ADDR_W-1:0]     hot_addr [8];

    // Geometries of the random phases; the last two are drawn at random.
    int phase_ins_words [NUM_PHASES] = '{3, 1, 256, 5, 0, 4, 2, 511, 0, 0};
    int phase_ins_lines [NUM_PHASES] = '{5, 1, 1024, 1000, 2047, 1024, 16, 1024, 0, 0};
    int phase_dat_words [NUM_PHASES] = '{7, 256, 1, 6, 511, 4, 17, 300, 0, 0};
    int phase_dat_lines [NUM_PHASES] = '{100, 1024, 1, 777, 0, 1024, 3, 1500, 0, 0};

    split_direct_mapped_cache_tags #(
        .MAX_LINES (MAX_LINES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sdmct_lookup_checker #(
        .MAX_LINES (MAX_LINES)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_data       (req_data),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp_data       (rsp_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .awaited_beats  (awaited_beats)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Result side: after each beat taken, stall for a drawn number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (rsp_valid && !rsp_stall)
        begin
            stall_draw = calm ? 0 : $urandom_range(0, 4);
            stall_left <= stall_draw;
            rsp_stall  <= (stall_draw != 0);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall  <= (stall_left > 1);
        end
    end

    // Offers one access beat after a drawn gap and returns at its accepting edge.
    task automatic send_access(input logic [ADDR_W-1:0] addr, input logic is_ins);
        int      gap;
        access_t beat;
        gap = calm ? 0 : $urandom_range(0, 4);
        beat.byte_address = addr;
        beat.ins_select   = is_ins;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= beat;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // Holds off the access side until every predicted result has arrived.
    task automatic drain_results();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_beats != 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Writes all four geometry registers; unused upper bits of the line size
    // registers carry random values.
    task automatic set_geometry(input int iw, input int il, input int dw, input int dl);
        logic [1:0] pad;
        pad = 2'($urandom_range(0, 3));
        write_reg(CFG_INS_LINE_WORDS, {pad, iw[WORDS_W-1:0]});
        write_reg(CFG_INS_NUM_LINES, il[CFG_DATA_W-1:0]);
        pad = 2'($urandom_range(0, 3));
        write_reg(CFG_DATA_LINE_WORDS, {pad, dw[WORDS_W-1:0]});
        write_reg(CFG_DATA_NUM_LINES, dl[CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    // Random accesses that mostly revisit a few hot regions, so that lines
    // hit, conflict and get replaced; the rest are fresh or fully random.
    task automatic run_phase(input int count);
        int                k;
        int                pick;
        logic [ADDR_W-1:0] addr;
        for (k = 0; k < 8; k++)
            hot_addr[k] = $urandom_range(0, 1) ? $urandom : ($urandom & 32'h0000_FFFF);
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                calm <= ($urandom_range(0, 3) == 0);
            k    = $urandom_range(0, 7);
            pick = $urandom_range(0, 9);
            if (pick < 6)
                addr = hot_addr[k] + $urandom_range(0, 15);
            else if (pick < 9)
            begin
                hot_addr[k] = $urandom_range(0, 1) ? $urandom : ($urandom & 32'h0003_FFFF);
                addr        = hot_addr[k];
            end
            else
                addr = $urandom;
            send_access(addr, 1'($urandom_range(0, 1)));
        end
        drain_results();
    endtask

    // Stimulus and verdict.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset geometry: first touch, hits in the same line, address
        // extremes, alternating bit patterns and an eviction at index zero.
        send_access(32'h0000_0000, 1'b1);
        send_access(32'h0000_0000, 1'b1);
        send_access(32'h0000_0003, 1'b0);
        send_access(32'h0000_0001, 1'b0);
        send_access(32'hFFFF_FFFF, 1'b1);
        send_access(32'hFFFF_FFFE, 1'b1);
        send_access(32'hFFFF_FFFD, 1'b0);
        send_access(32'hAAAA_AAAA, 1'b1);
        send_access(32'h5555_5555, 1'b0);
        send_access(32'h0000_4000, 1'b1);
        send_access(32'h0000_0000, 1'b1);
        drain_results();

        // Zero and oversized settings, which the block clamps.
        set_geometry(0, 0, 511, 2047);
        send_access(32'h0000_0000, 1'b1);
        send_access(32'h0000_0004, 1'b1);
        send_access(32'h0000_0004, 1'b1);
        send_access(32'hFFFF_FFFF, 1'b0);
        send_access(32'hFFFF_FC00, 1'b0);
        drain_results();

        // Largest legal instruction geometry, smallest data geometry; the
        // stores keep their contents across the change.
        set_geometry(256, 1024, 1, 1);
        send_access(32'h0000_0000, 1'b1);
        send_access(32'hFFFF_FFFF, 1'b1);
        send_access(32'h0000_0008, 1'b0);
        send_access(32'h0000_000C, 1'b0);
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p >= NUM_PHASES - 2)
                set_geometry($urandom_range(0, 511), $urandom_range(0, 2047),
                             $urandom_range(0, 511), $urandom_range(0, 2047));
            else
                set_geometry(phase_ins_words[p], phase_ins_lines[p],
                             phase_dat_words[p], phase_dat_lines[p]);
            run_phase(PHASE_ITEMS);
        end

        repeat (SETTLE_TICKS) @(posedge clk);
        if (mismatch_count == 0 && awaited_beats == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("FAIL");
        $finish;
    end

endmodule
